// ===== rtl/core/sga_pkg.sv =====
// ---------------------------------------------------------------------------
// sga_pkg
// Shared types, constants and arithmetic helpers of the score group
// aggregator: payload structs, mode codes, controller/datapath signals.
// ---------------------------------------------------------------------------
package sga_pkg;

    localparam int SCORE_W          = 24;
    localparam int COUNT_W          = 9;
    localparam int COUNT_LIMIT      = 511;
    localparam int MAX_CHILDREN_DEF = 256;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 3;
    localparam int MODE_W           = 3;
    localparam int DIV_STEPS        = SCORE_W;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

    localparam logic signed [31:0] Q_ONE     = 32'sd65536;
    localparam logic signed [31:0] SCORE_MAX = 32'sd8388607;
    localparam logic signed [31:0] SCORE_MIN = -32'sd8388608;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT = 2'd1;

    // fold modes, codes six and seven act as sum
    localparam logic [MODE_W-1:0] MODE_SUM   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MIN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MAX   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MEAN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PROD  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_PROD;

    typedef struct packed {
        logic signed [SCORE_W-1:0] item_score;
        logic                      active;
        logic                      veto;
        logic                      last_child;
    } sga_in_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] group_score;
        logic                      vetoed;
    } sga_out_t;

    typedef struct packed {
        logic capture;
        logic fold_commit;
        logic load_fold;
        logic div_step;
        logic load_div;
    } sga_cmd_t;

    typedef struct packed {
        logic fold_emit;
        logic fold_div;
        logic div_last;
    } sga_stat_t;

    function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [31:0] v);
        logic signed [SCORE_W-1:0] r;
        if (v > SCORE_MAX)
            r = SCORE_MAX[SCORE_W-1:0];
        else if (v < SCORE_MIN)
            r = SCORE_MIN[SCORE_W-1:0];
        else
            r = v[SCORE_W-1:0];
        return r;
    endfunction

    // optional one minus score, saturated
    function automatic logic signed [SCORE_W-1:0] finish_score(
        input logic signed [SCORE_W-1:0] s,
        input logic                      inv
    );
        logic signed [31:0] t;
        t = Q_ONE - $signed({{(32-SCORE_W){s[SCORE_W-1]}}, s});
        return inv ? sat_score(t) : s;
    endfunction

endpackage

// ===== rtl/core/score_group_aggregator.sv =====
// ---------------------------------------------------------------------------
// score_group_aggregator
// Folds the child scores of a group into one signed q8.16 group score.
// ---------------------------------------------------------------------------
// Children arrive on the item channel (valid/ready), one transfer each, with
// a last_child mark closing the group. Active scores are folded by the mode
// register: sum, min, max, mean, saturating product or first score above
// zero; invert turns the final score s into one minus s. A veto, a product
// that reaches zero or the first positive score in mode five closes the
// group early; children up to the last_child mark are then dropped.
// At most one result transfer per group leaves on the result channel.
// Each item is registered with the multiplier product, then folded; the next
// item is taken after the fold. The mean adds a bit-serial divide before the
// result is loaded. Registers are written on the cfg channel, which is always
// ready, while the block is idle; the user must keep to this, the block does
// not enforce it. Reset clears mode to product, invert and group state.
// The result register lets the next item in while a result waits; a fold
// that produces a result waits while the receiver stalls.
// ---------------------------------------------------------------------------
module score_group_aggregator #(
    parameter int MAX_CHILDREN = sga_pkg::MAX_CHILDREN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sga_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sga_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  sga_pkg::sga_in_t                item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output sga_pkg::sga_out_t               result
);
    import sga_pkg::*;

    sga_cmd_t  cmd;
    sga_stat_t st;

    assign cfg_ready = 1'b1;

    sga_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .st           (st),
        .cmd          (cmd)
    );

    sga_dp #(
        .MAX_CHILDREN (MAX_CHILDREN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .st        (st),
        .result    (result)
    );

endmodule

// ===== rtl/core/sga_ctrl.sv =====
// ---------------------------------------------------------------------------
// sga_ctrl
// Sequencer of the aggregator: takes an item, lets the datapath fold it,
// runs the mean divider when needed and owns the result valid flag.
// ---------------------------------------------------------------------------
module sga_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  sga_pkg::sga_stat_t st,
    output sga_pkg::sga_cmd_t  cmd
);
    import sga_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FOLD = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   out_free;

    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign item_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_FOLD;
                end
            end
            S_FOLD:
            begin
                if (st.fold_div)
                begin
                    cmd.fold_commit = 1'b1;
                    state_next      = S_DIV;
                end
                else if (st.fold_emit)
                begin
                    // hold the fold until the output register is free
                    if (out_free)
                    begin
                        cmd.fold_commit = 1'b1;
                        cmd.load_fold   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.fold_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_div = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result_valid_next = (result_valid_reg && !result_ready)
                             || cmd.load_fold || cmd.load_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

// ===== rtl/core/sga_dp.sv =====
// ---------------------------------------------------------------------------
// sga_dp
// Datapath of the aggregator: configuration registers, group state, the
// product multiplier, the fold logic, a bit-serial mean divider and the
// result register.
// ---------------------------------------------------------------------------
module sga_dp #(
    parameter int MAX_CHILDREN = sga_pkg::MAX_CHILDREN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sga_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sga_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  sga_pkg::sga_in_t                    item,
    input  sga_pkg::sga_cmd_t                   cmd,
    output sga_pkg::sga_stat_t                  st,
    output sga_pkg::sga_out_t                   result
);
    import sga_pkg::*;

    localparam int COUNT_CAP = (MAX_CHILDREN < COUNT_LIMIT) ? MAX_CHILDREN : COUNT_LIMIT;

    // configuration
    logic [MODE_W-1:0] mode_reg;
    logic              invert_reg;

    // group state
    logic signed [SCORE_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0]        cnt_reg, cnt_next;
    logic                      done_reg, done_next;

    // item and product stage
    sga_in_t                     item_reg;
    logic signed [2*SCORE_W-1:0] prod_reg;
    logic signed [2*SCORE_W-1:0] prod_adj;
    logic signed [SCORE_W-1:0]   prod_sat;

    // fold results
    logic signed [SCORE_W-1:0] s;
    logic signed [SCORE_W-1:0] acc_f;
    logic [COUNT_W-1:0]        cnt_f;
    logic                      first;
    logic                      f_emit;
    logic                      f_div;
    logic                      f_vflag;
    logic                      fin_en;
    logic signed [SCORE_W-1:0] pre_score;
    logic signed [SCORE_W-1:0] f_score;

    // divider
    logic [SCORE_W-1:0]   dvd_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   dvs_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [COUNT_W:0]     trial;
    logic                 trial_ge;
    logic signed [SCORE_W-1:0] quot;

    sga_out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            invert_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MODE)
                mode_reg <= cfg_data[MODE_W-1:0];
            else if (cfg_index == CFG_INVERT)
                invert_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
            prod_reg <= item.item_score * acc_reg;
        end
    end

    // round the q8.16 product toward zero
    assign prod_adj = prod_reg + (prod_reg[2*SCORE_W-1] ? 48'sd65535 : 48'sd0);
    assign prod_sat = sat_score($signed(prod_adj[47:16]));

    assign s     = item_reg.item_score;
    assign first = (cnt_reg == '0);

    always_comb
    begin
        acc_f     = acc_reg;
        cnt_f     = cnt_reg;
        f_emit    = 1'b0;
        f_div     = 1'b0;
        f_vflag   = 1'b0;
        fin_en    = 1'b0;
        pre_score = '0;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (done_reg)
        begin
            // rest of an ended group is dropped up to its last child
            if (item_reg.last_child)
            begin
                acc_next  = '0;
                cnt_next  = '0;
                done_next = 1'b0;
            end
        end
        else
        begin
            if (cnt_reg < COUNT_W'(COUNT_CAP))
                cnt_f = cnt_reg + 1'b1;
            if (item_reg.active)
            begin
                if (item_reg.veto)
                begin
                    f_emit  = 1'b1;
                    f_vflag = 1'b1;
                end
                else
                begin
                    unique case (mode_reg)
                        MODE_MIN:
                        begin
                            if (first || s < acc_reg)
                                acc_f = s;
                        end
                        MODE_MAX:
                        begin
                            if (first || s > acc_reg)
                                acc_f = s;
                        end
                        MODE_PROD:
                        begin
                            acc_f = first ? s : prod_sat;
                            if (acc_f == '0)
                            begin
                                f_emit = 1'b1;
                                fin_en = 1'b1;
                            end
                        end
                        MODE_FIRST:
                        begin
                            if (s > 0)
                            begin
                                f_emit    = 1'b1;
                                fin_en    = 1'b1;
                                pre_score = s;
                            end
                        end
                        default:
                        begin
                            acc_f = sat_score($signed({{8{acc_reg[SCORE_W-1]}}, acc_reg})
                                            + $signed({{8{s[SCORE_W-1]}}, s}));
                        end
                    endcase
                end
            end
            if (!f_emit && item_reg.last_child)
            begin
                if (mode_reg == MODE_MEAN)
                    f_div = 1'b1;
                else
                begin
                    f_emit    = 1'b1;
                    fin_en    = 1'b1;
                    pre_score = (mode_reg == MODE_FIRST) ? '0 : acc_f;
                end
            end
            if (item_reg.last_child)
            begin
                acc_next  = '0;
                cnt_next  = '0;
                done_next = 1'b0;
            end
            else
            begin
                acc_next  = acc_f;
                cnt_next  = cnt_f;
                done_next = f_emit;
            end
        end
        f_score = fin_en ? finish_score(pre_score, invert_reg) : pre_score;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (cmd.fold_commit)
        begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // restoring division of the sum magnitude by the child count
    assign trial    = {rem_reg, dvd_reg[SCORE_W-1]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.fold_commit && f_div)
        begin
            neg_reg  <= acc_f[SCORE_W-1];
            dvd_reg  <= acc_f[SCORE_W-1] ? (SCORE_W'(0) - SCORE_W'(acc_f))
                                         : SCORE_W'(acc_f);
            rem_reg  <= '0;
            dvs_reg  <= cnt_f;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= trial_ge ? COUNT_W'(trial - {1'b0, dvs_reg}) : trial[COUNT_W-1:0];
            dvd_reg  <= {dvd_reg[SCORE_W-2:0], trial_ge};
            step_reg <= step_reg + 1'b1;
        end
    end

    assign quot = neg_reg ? $signed(SCORE_W'(0) - dvd_reg) : $signed(dvd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_fold)
        begin
            result_reg.group_score <= f_score;
            result_reg.vetoed      <= f_vflag;
        end
        else if (cmd.load_div)
        begin
            result_reg.group_score <= finish_score(quot, invert_reg);
            result_reg.vetoed      <= 1'b0;
        end
    end

    assign result       = result_reg;
    assign st.fold_emit = f_emit;
    assign st.fold_div  = f_div;
    assign st.div_last  = (step_reg == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

// ===== rtl/core/sga_checker.sv =====
// ---------------------------------------------------------------------------
// sga_checker
// Port level checks of the score group aggregator, bound to the top level.
// ---------------------------------------------------------------------------
module sga_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            item_valid,
    input logic                            item_ready,
    input logic                            result_valid,
    input logic                            result_ready,
    input sga_pkg::sga_out_t               result
);
    import sga_pkg::*;

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // a veto always reports a zero score
    a_veto_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.vetoed |-> result.group_score == '0)
        else $error("vetoed result with nonzero score");

    // no two items are taken back to back
    a_item_gap: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken in back to back cycles");

    // a new result is only loaded from a fold or divide, never from idle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready))
        else $error("result appeared without work in progress");

endmodule

bind score_group_aggregator sga_checker u_sga_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for score_group_aggregator. A short stimulus table
// covers the score extremes, every fold mode and the early group endings.
// Random groups follow under changing mode and invert settings. Every result
// transfer is compared against a table entry or an in-bench fold of the same
// children. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import sga_pkg::*;

    localparam int KIDS_PARAM     = MAX_CHILDREN_DEF;
    localparam int KIDS_CAP       = (KIDS_PARAM < COUNT_LIMIT) ? KIDS_PARAM : COUNT_LIMIT;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    // code seven folds as sum
    localparam logic [MODE_W-1:0] MODE_SUM_ALT7 = 3'd7;

    localparam logic signed [SCORE_W-1:0] SC_MAX  = 24'sh7FFFFF;
    localparam logic signed [SCORE_W-1:0] SC_MIN  = 24'sh800000;
    localparam logic signed [SCORE_W-1:0] SC_ONE  = 24'sh010000;
    localparam logic signed [SCORE_W-1:0] SC_ZERO = 24'sh000000;

    typedef enum logic {ROW_REG, ROW_CHILD} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0]   data;
        sga_in_t                 child;
        bit                      typed;
        sga_out_t                want;
    } row_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    sga_in_t                item         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    sga_out_t               result;

    // in-bench copy of the group state and registers
    logic [MODE_W-1:0] mode_reg  = MODE_RESET;
    bit                inv_reg   = 1'b0;
    int                acc       = 0;
    int                kids_seen = 0;
    bit                closed    = 1'b0;

    sga_out_t pending_scores[$];
    int       mismatches  = 0;
    int       stall_left  = 0;
    int       idle_cycles = 0;
    bit       tx_steady   = 1'b0;
    bit       rx_steady   = 1'b0;

    score_group_aggregator #(
        .MAX_CHILDREN (KIDS_PARAM)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int clamp24(input longint v);
        if (v > longint'(SCORE_MAX))
            return int'(SCORE_MAX);
        if (v < longint'(SCORE_MIN))
            return int'(SCORE_MIN);
        return int'(v);
    endfunction

    // q8.16 product, magnitude truncated so rounding is toward zero
    function automatic int mul_q816(input int a, input int b);
        longint p;
        longint m;
        p = longint'(a) * longint'(b);
        m = (p < 0) ? -p : p;
        m = m >> 16;
        return clamp24((p < 0) ? -m : m);
    endfunction

    function automatic int one_minus(input int s);
        return inv_reg ? clamp24(longint'(Q_ONE) - longint'(s)) : s;
    endfunction

    function automatic void clear_group();
        acc       = 0;
        kids_seen = 0;
        closed    = 1'b0;
    endfunction

    // folds one child into the group, returns 1 when a group result is due
    function automatic bit fold_child(input sga_in_t c, output sga_out_t r);
        int s;
        int fin;
        int score;
        bit first;
        bit emit;
        bit vflag;
        s     = int'(c.item_score);
        first = (kids_seen == 0);
        emit  = 1'b0;
        score = 0;
        vflag = 1'b0;
        r     = '0;
        if (closed)
        begin
            if (c.last_child)
                clear_group();
            return 1'b0;
        end
        if (kids_seen < KIDS_CAP)
            kids_seen++;
        if (c.active)
        begin
            if (c.veto)
            begin
                emit  = 1'b1;
                vflag = 1'b1;
            end
            else
            begin
                case (mode_reg)
                    MODE_MIN:
                        if (first || s < acc)
                            acc = s;
                    MODE_MAX:
                        if (first || s > acc)
                            acc = s;
                    MODE_PROD:
                    begin
                        acc = first ? s : mul_q816(acc, s);
                        if (acc == 0)
                        begin
                            emit  = 1'b1;
                            score = inv_reg ? int'(Q_ONE) : 0;
                        end
                    end
                    MODE_FIRST:
                        if (s > 0)
                        begin
                            emit  = 1'b1;
                            score = one_minus(s);
                        end
                    default:
                        acc = clamp24(longint'(acc) + longint'(s));
                endcase
            end
        end
        if (emit)
            closed = 1'b1;
        else if (c.last_child)
        begin
            fin = acc;
            if (mode_reg == MODE_FIRST)
                fin = 0;
            // mean divides by every child seen up to KIDS_CAP, truncating toward zero
            if (mode_reg == MODE_MEAN)
                fin = fin / kids_seen;
            score = one_minus(fin);
            emit  = 1'b1;
        end
        if (c.last_child)
            clear_group();
        r.group_score = score[SCORE_W-1:0];
        r.vetoed      = vflag;
        return emit;
    endfunction

    // mostly short pauses, a few long ones
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 92)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [SCORE_W-1:0] pick_score();
        logic [31:0] rnd;
        int          r;
        int          v;
        r   = $urandom_range(0, 99);
        rnd = $urandom;
        if (r < 30)
            return rnd[SCORE_W-1:0];
        if (r < 50)
        begin
            v = int'($urandom_range(0, 196608)) - 98304;
            return v[SCORE_W-1:0];
        end
        if (r < 70)
        begin
            // near one, keeps products alive for a while
            v = int'($urandom_range(49152, 81920));
            if (rnd[0])
                v = -v;
            return v[SCORE_W-1:0];
        end
        if (r < 80)
            return SC_ZERO;
        if (r < 90)
        begin
            case (rnd[1:0])
                2'd0:    return SC_MAX;
                2'd1:    return SC_MIN;
                2'd2:    return SC_ONE;
                default: return -24'sd1;
            endcase
        end
        v = int'($urandom_range(0, 255));
        if (rnd[0])
            v = -v;
        return v[SCORE_W-1:0];
    endfunction

    function automatic row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        row_t w;
        w       = '{kind: ROW_REG, idx: idx, data: data, child: '0, typed: 1'b0, want: '0};
        return w;
    endfunction

    function automatic row_t kid_row(input logic signed [SCORE_W-1:0] sc,
                                     input bit act, input bit vet, input bit lst);
        row_t w;
        w                  = '{kind: ROW_CHILD, idx: '0, data: '0, child: '0, typed: 1'b0,
                               want: '0};
        w.child.item_score  = sc;
        w.child.active      = act;
        w.child.veto        = vet;
        w.child.last_child  = lst;
        return w;
    endfunction

    function automatic row_t kid_want(input logic signed [SCORE_W-1:0] sc,
                                      input bit act, input bit vet, input bit lst,
                                      input logic signed [SCORE_W-1:0] w_sc, input bit w_v);
        row_t w;
        w                  = kid_row(sc, act, vet, lst);
        w.typed            = 1'b1;
        w.want.group_score = w_sc;
        w.want.vetoed      = w_v;
        return w;
    endfunction

    task automatic send_child(input sga_in_t c, input bit typed, input sga_out_t want);
        sga_out_t r;
        bit       got;
        int       gap;
        if (!tx_steady && $urandom_range(0, 99) < 35)
        begin
            gap        = pause_len();
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= c;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        got = fold_child(c, r);
        if (typed)
            pending_scores.push_back(want);
        else if (got)
            pending_scores.push_back(r);
    endtask

    // no results outstanding, then room for a child that is still folding
    task automatic drain();
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        item_valid <= 1'b0;
        drain();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MODE)
            mode_reg = data[MODE_W-1:0];
        else if (idx == CFG_INVERT)
            inv_reg = data[0];
    endtask

    // result side: random stalls, some phases always ready
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (!rx_steady && $urandom_range(0, 99) < 25)
        begin
            result_ready <= 1'b0;
            stall_left   <= pause_len() - 1;
        end
        else
            result_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        sga_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_scores.size() == 0)
            begin
                $error("result with no group pending: group_score %0d vetoed %0b",
                       result.group_score, result.vetoed);
                mismatches++;
            end
            else
            begin
                want = pending_scores.pop_front();
                if (result.group_score !== want.group_score)
                begin
                    $error("group_score: expected %0d, actual %0d",
                           want.group_score, result.group_score);
                    mismatches++;
                end
                if (result.vetoed !== want.vetoed)
                begin
                    $error("vetoed: expected %0b, actual %0b", want.vetoed, result.vetoed);
                    mismatches++;
                end
            end
        end
    end

    // counts cycles without any transfer
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        row_t        plan[$];
        sga_in_t     c;
        logic [31:0] rnd;
        logic [MODE_W-1:0] m;
        bit          v;
        bit          long_done;
        int          phase;
        int          sent;
        int          groups;
        int          n;
        int          r;
        int          vet_pct;

        plan = '{
            // product after reset
            kid_want(SC_ONE, 1, 0, 1, SC_ONE, 0),
            kid_row(SC_MAX, 1, 0, 0),
            kid_want(SC_MAX, 1, 0, 1, SC_MAX, 0),
            // product hits zero, rest of the group dropped
            kid_want(SC_ZERO, 1, 0, 0, SC_ZERO, 0),
            kid_row(SC_MAX, 1, 1, 0),
            kid_row(SC_MIN, 1, 0, 1),
            // veto on the last child
            kid_want(SC_MIN, 1, 1, 1, SC_ZERO, 1),
            reg_row(CFG_INVERT, 3'd1),
            // product rounds to zero, inverted
            kid_row(24'sd2, 1, 0, 0),
            kid_want(24'sd2, 1, 0, 1, SC_ONE, 0),
            reg_row(CFG_MODE, MODE_SUM),
            kid_want(SC_MIN, 1, 0, 1, SC_MAX, 0),
            // inactive child ignores its veto
            kid_row(SC_MAX, 0, 1, 1),
            reg_row(CFG_INVERT, 3'd0),
            kid_row(SC_MIN, 1, 0, 0),
            kid_want(SC_MIN, 1, 0, 1, SC_MIN, 0),
            // inactive first child still takes the seed slot
            reg_row(CFG_MODE, MODE_MIN),
            kid_row(24'sh123456, 0, 0, 0),
            kid_row(-24'sd3, 1, 0, 0),
            kid_row(24'sd7, 1, 0, 1),
            reg_row(CFG_MODE, MODE_MAX),
            kid_row(SC_MIN, 1, 0, 0),
            kid_row(-24'sd5, 1, 0, 1),
            reg_row(CFG_MODE, MODE_MEAN),
            kid_row(SC_MAX, 1, 0, 0),
            kid_row(SC_ZERO, 0, 0, 0),
            kid_row(-24'sd100, 1, 0, 1),
            reg_row(CFG_MODE, MODE_FIRST),
            kid_want(SC_ZERO, 1, 0, 1, SC_ZERO, 0),
            kid_row(24'sh008000, 1, 0, 0),
            kid_row(SC_ZERO, 1, 0, 1),
            reg_row(CFG_MODE, MODE_SUM_ALT7),
            kid_row(SC_MAX, 1, 0, 1)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_child(plan[i].child, plan[i].typed, plan[i].want);
        end

        phase     = 0;
        sent      = 0;
        long_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            // first sixteen phases sweep every mode with and without invert
            if (phase < 16)
            begin
                m = phase[MODE_W-1:0];
                v = phase[3];
            end
            else
            begin
                m = MODE_W'($urandom_range(0, 7));
                v = 1'($urandom_range(0, 1));
            end
            write_reg(CFG_MODE, m);
            write_reg(CFG_INVERT, {2'b00, v});
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            groups    = $urandom_range(3, 10);
            for (int g = 0; g < groups; g++)
            begin
                vet_pct = 4;
                r       = $urandom_range(0, 99);
                if (r < 70)
                    n = $urandom_range(1, 4);
                else if (r < 95)
                    n = $urandom_range(5, 12);
                else
                    n = $urandom_range(13, 30);
                // one oversized mean group runs the child count into its cap
                if (m == MODE_MEAN && !long_done)
                begin
                    n         = KIDS_CAP + 24;
                    vet_pct   = 0;
                    long_done = 1'b1;
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: every field random, last mark anywhere
                    for (int k = 0; k < n; k++)
                    begin
                        rnd           = $urandom;
                        c.item_score  = rnd[SCORE_W-1:0];
                        c.active      = rnd[24];
                        c.veto        = rnd[25];
                        c.last_child  = rnd[26];
                        send_child(c, 1'b0, '0);
                    end
                end
                else
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        c.item_score  = pick_score();
                        c.active      = ($urandom_range(0, 99) < 85);
                        c.veto        = ($urandom_range(0, 99) < vet_pct);
                        c.last_child  = (k == n - 1);
                        send_child(c, 1'b0, '0);
                    end
                end
                sent += n;
            end
            phase++;
        end

        item_valid <= 1'b0;
        drain();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sga_pkg.sv
rtl/core/sga_ctrl.sv
rtl/core/sga_dp.sv
rtl/core/score_group_aggregator.sv
rtl/core/sga_checker.sv
bench/tb_top.sv
